/* hdl/assert_macros.svh */
// Assertion macros shared by the sorted list RTL; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define SDL_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");
// Check a same-cycle implication.
`define SDL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Check a next-cycle implication.
`define SDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SDL_ASSERT_HOLDS(lbl, expr)
`define SDL_ASSERT_IMPL(lbl, ante, cons)
`define SDL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/sdl_pkg.sv */
// Shared types and constants of the sorted descending list.
package sdl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_POP_HEAD = 2'd1,
    REQ_POP_TAIL = 2'd2,
    REQ_REMOVE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_DONE      = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic commit;
  } sdl_cmd_t;

endpackage

/* hdl/sdl_ctrl.sv */
// Controller: request sequencing and result handshake.
`include "assert_macros.svh"

module sdl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sdl_pkg::sdl_cmd_t cmd
);
  import sdl_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold the request until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `SDL_ASSERT_NEXT(a_accept_to_exec, in_valid && in_ready, state_r == S_EXEC)
  `SDL_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_r)
  `SDL_ASSERT_IMPL(a_no_load_and_commit, cmd.commit, !cmd.load_req && !in_ready)

endmodule

/* hdl/sdl_dpath.sv */
// Datapath: sorted entry cells, request register and result register.
`include "assert_macros.svh"

module sdl_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdl_pkg::sdl_cmd_t                 cmd,
  input  logic [1:0]                        in_req_type,
  input  logic signed [sdl_pkg::VAL_W-1:0]  in_value,
  output logic [1:0]                        out_status,
  output logic signed [sdl_pkg::VAL_W-1:0]  out_result_value,
  output logic [sdl_pkg::CNT_W-1:0]         out_count
);
  import sdl_pkg::*;

  req_t                    req_r;
  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] entries_r   [CAPACITY];
  logic signed [VAL_W-1:0] entries_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]        out_count_r;

  logic [CAPACITY-1:0]     ge, eq, hit_pre, prev_ge;
  logic signed [VAL_W-1:0] shift_up [CAPACITY];
  logic signed [VAL_W-1:0] shift_dn [CAPACITY];
  logic                    full, empty, found;
  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        tail_idx;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= req_t'(in_req_type);
      value_r <= in_value;
    end
  end

  // compare every stored cell against the request value in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (entries_r[i] >= value_r);
      eq[i] = (CNT_W'(i) < count_r) && (entries_r[i] == value_r);
    end
    hit_pre[0]  = eq[0];
    prev_ge[0]  = 1'b1;
    shift_up[0] = value_r;
    for (int i = 1; i < CAPACITY; i++) begin
      hit_pre[i]  = hit_pre[i-1] | eq[i];
      prev_ge[i]  = ge[i-1];
      shift_up[i] = entries_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      shift_dn[i] = entries_r[i+1];
    end
    shift_dn[CAPACITY-1] = entries_r[CAPACITY-1];
  end

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);
  assign found    = hit_pre[CAPACITY-1];
  assign cnt_m1   = count_r - CNT_W'(1);
  assign tail_idx = cnt_m1[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = entries_r[i];
    count_nxt      = count_r;
    out_status_nxt = STS_DONE;
    out_value_nxt  = '0;
    unique case (req_r)
      REQ_INSERT: begin
        if (full) begin
          out_status_nxt = STS_FULL;
        end else begin
          // cells below the insert point hold, the rest move one toward the tail
          for (int i = 0; i < CAPACITY; i++) begin
            if (!ge[i]) entries_nxt[i] = prev_ge[i] ? value_r : shift_up[i];
          end
          count_nxt     = count_r + CNT_W'(1);
          out_value_nxt = value_r;
        end
      end
      REQ_POP_HEAD: begin
        if (empty) begin
          out_status_nxt = STS_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY; i++) entries_nxt[i] = shift_dn[i];
          count_nxt     = cnt_m1;
          out_value_nxt = entries_r[0];
        end
      end
      REQ_POP_TAIL: begin
        if (empty) begin
          out_status_nxt = STS_EMPTY;
        end else begin
          count_nxt     = cnt_m1;
          out_value_nxt = entries_r[tail_idx];
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          out_status_nxt = STS_EMPTY;
        end else if (!found) begin
          out_status_nxt = STS_NOT_FOUND;
        end else begin
          // close up behind the first match
          for (int i = 0; i < CAPACITY; i++) begin
            if (hit_pre[i]) entries_nxt[i] = shift_dn[i];
          end
          count_nxt     = cnt_m1;
          out_value_nxt = value_r;
        end
      end
      default: out_status_nxt = STS_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) entries_r[i] <= entries_nxt[i];
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_count        = out_count_r;

  `SDL_ASSERT_HOLDS(a_count_bounded, count_r <= CNT_W'(CAPACITY))
  `SDL_ASSERT_NEXT(a_insert_grows, cmd.commit && req_r == REQ_INSERT && !full,
                   count_r == $past(count_r) + CNT_W'(1))
  `SDL_ASSERT_NEXT(a_fail_keeps_count, cmd.commit && out_status_nxt != STS_DONE,
                   count_r == $past(count_r) && out_value_r == '0)

endmodule

/* hdl/sorted_descending_list.sv */
// Top level of the sorted descending list.
//
// Holds up to 16 signed 32-bit values, largest at the head. Each request on
// the in_ channel (in_req_type, in_value) is one of: insert in order, pop the
// largest, pop the smallest, or remove the first entry equal to in_value.
// Every request gives exactly one result on the out_ channel: a status
// (done, full, empty, not found), the inserted or removed value (zero on any
// failure) and the entry count after the request.
// A request is first captured in the request register, then committed in
// execute to the result register, which raises out_valid; execute waits
// while the result register holds a result that is not being taken.
// A new request is taken only in idle, once the previous one has left
// execute; the cell array is updated when execute commits, and each request
// waits in the request register before it.
// The result register lets the next request be taken while a result waits;
// if out_ready stays low, that next request holds in execute and in_ready
// stays low until the waiting result is taken.
// Reset (rst_n low, synchronous) empties the list, clears out_valid and returns to idle.
module sorted_descending_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic signed [sdl_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [sdl_pkg::VAL_W-1:0]  out_result_value,
  output logic [sdl_pkg::CNT_W-1:0]         out_count
);
  import sdl_pkg::*;

  sdl_cmd_t cmd;

  sdl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sdl_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_count        (out_count)
  );

endmodule
